// File: design/masked_context_hash_defines.svh
// Assertion macros used by the masked context hash top level.
`ifndef MASKED_CONTEXT_HASH_DEFINES_SVH
`define MASKED_CONTEXT_HASH_DEFINES_SVH

`ifndef ASSERT_OFF
`define MCH_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("masked_context_hash assertion failed");
`define MCH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("masked_context_hash assertion failed");
`else
`define MCH_ASSERT(label, clk, rst_n, prop)
`define MCH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: design/mch_pkg.sv
// Types and constants of the masked context hash.
`timescale 1ns / 1ps

package mch_pkg;

	localparam logic [31:0] HASH_MULT = 32'h0000_006f;
	localparam logic [31:0] HIGH_MASK = 32'hffff_ff00;
	localparam int unsigned ROT_BITS = 9;
	localparam int unsigned NUM_CELLS = 9;
	// One head stage, one stage per cell and the output stage.
	localparam int unsigned LATENCY = NUM_CELLS + 2;

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_MUL = 2'd1,
		MODE_ROT = 2'd2
	} mode_t;

	// Request travelling down the cell chain. Element 0 of vals is the next
	// value to be mixed in; en marks which of them take part.
	typedef struct packed {
		logic                  valid;
		logic [31:0]           h;
		logic [NUM_CELLS-1:0]  en;
		logic [NUM_CELLS-1:0][7:0] vals;
	} tok_t;

endpackage

// File: design/mch_cell.sv
// One round cell of the hash chain: mixes one byte into the running hash if it is enabled.
`timescale 1ns / 1ps

module mch_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    mode,
	input  mch_pkg::tok_t tok_in,
	output mch_pkg::tok_t tok_out
);

	logic [31:0] v;
	logic [31:0] add_prod;
	logic [31:0] xin;
	logic [31:0] frot;
	logic [31:0] fmul;
	logic [31:0] fsel;
	logic [31:0] zsum;
	logic [31:0] h_next;
	logic        valid_q;
	logic [31:0] h_q;
	logic [mch_pkg::NUM_CELLS-1:0] en_q;
	logic [mch_pkg::NUM_CELLS-1:0][7:0] vals_q;

	assign v = {24'd0, tok_in.vals[0]};

	always_comb begin
		add_prod = (tok_in.h + v) * mch_pkg::HASH_MULT;
		xin = {tok_in.h[31:8], tok_in.h[7:0] ^ tok_in.vals[0]};
		fmul = xin * mch_pkg::HASH_MULT;
		frot = {xin[31-mch_pkg::ROT_BITS:0], xin[31:32-mch_pkg::ROT_BITS]};
		fsel = (mode == mch_pkg::MODE_ROT) ? frot : fmul;
		zsum = {fsel[31:8], fsel[7:0] + tok_in.vals[0]};
		if (!tok_in.en[0]) begin
			h_next = tok_in.h;
		end else begin
			case (mode)
				mch_pkg::MODE_ADD: h_next = add_prod ^ v;
				default:           h_next = zsum - 32'd1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
		end
	end

	// The consumed value drops off and the rest move one place down.
	always_ff @(posedge clk) begin
		h_q <= h_next;
		en_q <= tok_in.en >> 1;
		vals_q <= tok_in.vals >> 8;
	end

	assign tok_out = '{valid: valid_q, h: h_q, en: en_q, vals: vals_q};

endmodule

// File: design/mch_mix.sv
// Final shift-xor mix of the additive hash and the result register.
`timescale 1ns / 1ps

module mch_mix (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    mode,
	input  mch_pkg::tok_t tok_in,
	output logic          done,
	output logic [31:0]   hash_value
);

	logic [31:0] m1;
	logic [31:0] m2;
	logic        done_q;
	logic [31:0] hash_q;

	always_comb begin
		m1 = tok_in.h ^ (tok_in.h >> 20) ^ (tok_in.h >> 12);
		m2 = m1 ^ (m1 >> 7) ^ (m1 >> 4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		hash_q <= (mode == mch_pkg::MODE_ADD) ? m2 : tok_in.h;
	end

	assign done = done_q;
	assign hash_value = hash_q;

endmodule

// File: design/masked_context_hash.sv
// Masked context hash: top level with the head stage and the cell chain.
// A key is taken on every cycle in which start is high; busy never rises, so
// one key per clock is sustained. Each key comes out on hash_value, marked by
// a one-cycle done strobe, in the order taken; it passes through one head
// stage, nine round cells (partial byte, then history bytes 0 to 7) and the
// output register. The receiver cannot stall, so results must be taken as
// they appear. Write hash_mode only while no request is in flight.
`timescale 1ns / 1ps
`include "masked_context_hash_defines.svh"

module masked_context_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode_wr_en,
	input  logic [1:0]  mode_wr_data,
	input  logic [31:0] salt,
	input  logic [7:0]  byte_mask,
	input  logic [7:0]  partial_byte,
	input  logic [7:0]  history_byte_0,
	input  logic [7:0]  history_byte_1,
	input  logic [7:0]  history_byte_2,
	input  logic [7:0]  history_byte_3,
	input  logic [7:0]  history_byte_4,
	input  logic [7:0]  history_byte_5,
	input  logic [7:0]  history_byte_6,
	input  logic [7:0]  history_byte_7,
	output logic        done,
	output logic [31:0] hash_value
);

	logic [1:0]    hash_mode_q;
	logic          accept;
	logic [31:0]   mask_ext;
	logic [31:0]   h_init;
	logic          head_valid_s1;
	logic [31:0]   head_h_s1;
	logic [mch_pkg::NUM_CELLS-1:0] head_en_s1;
	logic [mch_pkg::NUM_CELLS-1:0][7:0] head_vals_s1;
	mch_pkg::tok_t chain [0:mch_pkg::NUM_CELLS];

	assign busy = 1'b0;
	assign accept = start && !busy;
	assign mask_ext = {24'd0, byte_mask};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_mode_q <= mch_pkg::MODE_MUL;
		end else if (mode_wr_en) begin
			hash_mode_q <= mode_wr_data;
		end
	end

	// The additive hash starts by mixing in the mask itself; the salted
	// hashes start from the salt with the mask in the low byte.
	always_comb begin
		if (hash_mode_q == mch_pkg::MODE_ADD) begin
			h_init = (mask_ext * mch_pkg::HASH_MULT) ^ mask_ext;
		end else begin
			h_init = (salt & mch_pkg::HIGH_MASK) | mask_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_s1 <= 1'b0;
		end else begin
			head_valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		head_h_s1 <= h_init;
		head_en_s1 <= {byte_mask[0], byte_mask[1], byte_mask[2], byte_mask[3],
			byte_mask[4], byte_mask[5], byte_mask[6], byte_mask[7], 1'b1};
		head_vals_s1 <= {history_byte_7, history_byte_6, history_byte_5,
			history_byte_4, history_byte_3, history_byte_2, history_byte_1,
			history_byte_0, partial_byte};
	end

	assign chain[0] = '{valid: head_valid_s1, h: head_h_s1, en: head_en_s1,
		vals: head_vals_s1};

	for (genvar g = 0; g < mch_pkg::NUM_CELLS; g++) begin : g_cell
		mch_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.mode   (hash_mode_q),
			.tok_in (chain[g]),
			.tok_out(chain[g+1])
		);
	end

	mch_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (hash_mode_q),
		.tok_in    (chain[mch_pkg::NUM_CELLS]),
		.done      (done),
		.hash_value(hash_value)
	);

	`MCH_ASSERT(a_latency, clk, arst_n, accept |-> ##11 done)
	`MCH_ASSERT(a_no_spurious, clk, arst_n, done |-> $past(accept, 11))
	`MCH_ASSERT_NEXT(a_mode_write, clk, arst_n, mode_wr_en, hash_mode_q == $past(mode_wr_data))

endmodule
